[design/fcbp_pkg.sv]
// Shared types and constants for the 8.3 file name parser.
// Used by the classifier, the item queue, the parse engine and the top level.
package fcbp_pkg;

  localparam int unsigned NAME_MAX = 8;
  localparam int unsigned EXT_MAX  = 3;
  localparam int unsigned DRV_W    = 26;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_QM    = 8'h3f;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_PIPE  = 8'h7c;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_WILD     = 2'd1;
  localparam logic [1:0] ST_BAD_DRV  = 2'd2;

  // Character after classification: upper-cased byte plus class flags.
  typedef struct packed {
    logic [7:0] up;
    logic       is_nul;
    logic       is_dot;
    logic       is_star;
    logic       is_qm;
    logic       is_colon;
    logic       is_csep;
    logic       is_ws;
    logic       is_fsep;
  } chinfo_t;

  typedef struct packed {
    chinfo_t    info;
    logic       start_req;
    logic [3:0] mode;
  } qitem_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [4:0]            drive;
    logic                  drive_wr;
    logic [NAME_MAX*8-1:0] name_chars;
    logic [7:0]            name_mask;
    logic [EXT_MAX*8-1:0]  ext_chars;
    logic                  ext_wr;
    logic [15:0]           consumed;
  } res_t;

endpackage

[design/fcbp_front.sv]
// Front classifier: turns each incoming byte into an upper-cased byte and class flags.
// Depends on fcbp_pkg for the character constants and the queue item type.
module fcbp_front import fcbp_pkg::*; (
  input  logic [7:0] in_ch,
  input  logic       in_start_req,
  input  logic [3:0] in_mode,
  output qitem_t     item
);

  logic is_ws;
  logic is_csep;
  logic is_fsep;
  logic is_lower;

  assign is_ws    = (in_ch == CH_SPACE) || (in_ch == CH_TAB);
  assign is_csep  = is_ws || (in_ch == CH_COLON) || (in_ch == CH_SEMI) ||
                    (in_ch == CH_COMMA) || (in_ch == CH_EQ) || (in_ch == CH_PLUS);
  // Every byte from 0x00 up to and including the space counts as a field separator.
  assign is_fsep  = (in_ch <= CH_SPACE) || (in_ch == CH_SLASH) || (in_ch == CH_BSL) ||
                    (in_ch == CH_DQUOT) || (in_ch == CH_LBRK) || (in_ch == CH_RBRK) ||
                    (in_ch == CH_LT) || (in_ch == CH_GT) || (in_ch == CH_PIPE) ||
                    (in_ch == CH_DOT) || (in_ch == CH_COLON) || (in_ch == CH_SEMI) ||
                    (in_ch == CH_COMMA) || (in_ch == CH_EQ) || (in_ch == CH_PLUS);
  assign is_lower = (in_ch >= CH_LA) && (in_ch <= CH_LZ);

  always_comb begin
    item.info.up       = is_lower ? (in_ch - CASE_OFS) : in_ch;
    item.info.is_nul   = (in_ch == CH_NUL);
    item.info.is_dot   = (in_ch == CH_DOT);
    item.info.is_star  = (in_ch == CH_STAR);
    item.info.is_qm    = (in_ch == CH_QM);
    item.info.is_colon = (in_ch == CH_COLON);
    item.info.is_csep  = is_csep;
    item.info.is_ws    = is_ws;
    item.info.is_fsep  = is_fsep;
    item.start_req     = in_start_req;
    item.mode          = in_mode;
  end

endmodule

[design/fcbp_queue.sv]
// Short queue of classified words between the front classifier and the parse engine.
// Depends on fcbp_pkg for the item type and the queue depth.
module fcbp_queue import fcbp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qitem_t push_item,
  output logic   full,
  input  logic   pop,
  output qitem_t pop_item,
  output logic   not_empty
);

  qitem_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[design/fcbp_back.sv]
// Parse engine: runs the separator skip, drive lookahead and name/extension fill
// one queued word per unstalled cycle, and holds the finished result in an output register.
// Depends on fcbp_pkg for the word and result types and the character constants.
module fcbp_back import fcbp_pkg::*; #(
  parameter int unsigned NAME_LEN    = 8,
  parameter int unsigned EXT_LEN     = 3,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DRV_W-1:0]  valid_drives,
  input  logic              q_not_empty,
  input  qitem_t            q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output res_t              res
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_LOOK   = 3'd2;
  localparam logic [2:0] PH_NSTART = 3'd3;
  localparam logic [2:0] PH_DOT    = 3'd4;
  localparam logic [2:0] PH_NAME   = 3'd5;
  localparam logic [2:0] PH_AFTER  = 3'd6;
  localparam logic [2:0] PH_EXT    = 3'd7;

  localparam logic [7:0] NAME_ALL = 8'((16'd1 << NAME_LEN) - 16'd1);

  typedef struct packed {
    logic [2:0]             phase;
    logic [3:0]             mode;
    chinfo_t                held;
    logic [NAME_MAX*8-1:0]  name_buf;
    logic [EXT_MAX*8-1:0]   ext_buf;
    logic [3:0]             idx;
    logic                   wild;
    logic [4:0]             drv;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [7:0]             wmask;
    logic                   ext_wr;
    logic                   drv_wr;
  } pst_t;

  typedef struct packed {
    pst_t st;
    logic fire;
  } feed_t;

  pst_t        st_r;
  pst_t        st_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  res_t        res_r;
  res_t        res_nxt;
  logic        fire;
  logic        bad;
  feed_t       f1;
  feed_t       f2;
  logic [7:0]  drv_ofs;
  logic        drv_ok;
  logic [15:0] cnt_sat;

  function automatic logic [COUNT_WIDTH-1:0] cnt_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic pst_t clear_state(input logic [3:0] mode);
    pst_t s;
    s          = '0;
    s.phase    = PH_SKIP;
    s.mode     = mode;
    s.name_buf = {NAME_MAX{CH_SPACE}};
    s.ext_buf  = {EXT_MAX{CH_SPACE}};
    return s;
  endfunction

  function automatic pst_t idle_state();
    pst_t s;
    s       = clear_state(4'd0);
    s.phase = PH_IDLE;
    return s;
  endfunction

  function automatic pst_t begin_name(input pst_t si);
    pst_t s;
    s        = si;
    s.wmask  = s.mode[2] ? 8'h00 : NAME_ALL;
    s.ext_wr = !s.mode[3];
    s.phase  = PH_NSTART;
    return s;
  endfunction

  function automatic pst_t no_drive(input pst_t si);
    pst_t s;
    s = si;
    if (!s.mode[1]) begin
      s.drv_wr = 1'b1;
      s.drv    = '0;
    end
    return begin_name(s);
  endfunction

  function automatic pst_t start_ext(input pst_t si);
    pst_t s;
    s        = si;
    s.cnt    = cnt_inc(s.cnt);
    s.ext_wr = 1'b1;
    s.idx    = '0;
    s.phase  = PH_EXT;
    return s;
  endfunction

  // One character of the name/extension part of the parse.
  function automatic feed_t feed(input pst_t si, input chinfo_t c);
    feed_t r;
    logic  done;
    r.st   = si;
    r.fire = 1'b0;
    done   = 1'b0;
    if (r.st.phase == PH_NSTART) begin
      if (c.is_dot) begin
        r.st.name_buf[7:0] = CH_DOT;
        r.st.wmask[0]      = 1'b1;
        r.st.cnt           = cnt_inc(r.st.cnt);
        r.st.phase         = PH_DOT;
        done               = 1'b1;
      end else begin
        r.st.phase = PH_NAME;
        r.st.idx   = '0;
        r.st.wmask = NAME_ALL;
      end
    end
    if (!done) begin
      unique case (r.st.phase)
        PH_DOT: begin
          if (c.is_dot) begin
            if (NAME_LEN > 1) begin
              r.st.name_buf[15:8] = CH_DOT;
              r.st.wmask[1]       = 1'b1;
            end
            r.st.cnt = cnt_inc(r.st.cnt);
          end
          r.st.wild = 1'b0;
          r.fire    = 1'b1;
        end
        PH_NAME: begin
          if (c.is_fsep) begin
            if (c.is_dot) begin
              r.st = start_ext(r.st);
            end else begin
              r.fire = 1'b1;
            end
          end else if (c.is_star) begin
            r.st.wild = 1'b1;
            for (int i = 0; i < NAME_MAX; i++) begin
              if ((i >= r.st.idx) && (i < NAME_LEN)) begin
                r.st.name_buf[i*8 +: 8] = CH_QM;
              end
            end
            r.st.cnt   = cnt_inc(r.st.cnt);
            r.st.phase = PH_AFTER;
          end else begin
            if (c.is_qm) begin
              r.st.wild = 1'b1;
            end
            r.st.name_buf[r.st.idx[2:0]*8 +: 8] = c.up;
            r.st.idx = r.st.idx + 4'd1;
            r.st.cnt = cnt_inc(r.st.cnt);
            if (r.st.idx >= NAME_LEN) begin
              r.st.phase = PH_AFTER;
            end
          end
        end
        PH_AFTER: begin
          if (c.is_dot) begin
            r.st = start_ext(r.st);
          end else begin
            r.fire = 1'b1;
          end
        end
        PH_EXT: begin
          if (c.is_fsep) begin
            r.fire = 1'b1;
          end else if (c.is_star) begin
            r.st.wild = 1'b1;
            for (int i = 0; i < EXT_MAX; i++) begin
              if ((i >= r.st.idx) && (i < EXT_LEN)) begin
                r.st.ext_buf[i*8 +: 8] = CH_QM;
              end
            end
            r.st.cnt = cnt_inc(r.st.cnt);
            r.fire   = 1'b1;
          end else begin
            if (c.is_qm) begin
              r.st.wild = 1'b1;
            end
            r.st.ext_buf[r.st.idx[1:0]*8 +: 8] = c.up;
            r.st.idx = r.st.idx + 4'd1;
            r.st.cnt = cnt_inc(r.st.cnt);
            if (r.st.idx >= EXT_LEN) begin
              r.fire = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (r.fire) begin
      r.st.phase = PH_IDLE;
    end
    return r;
  endfunction

  assign q_pop   = q_not_empty && (!out_valid_r || !out_stall);
  assign drv_ofs = st_r.held.up - CH_UA;
  assign drv_ok  = (drv_ofs < 8'd26) && valid_drives[drv_ofs[4:0]];

  always_comb begin
    pst_t s;
    s    = st_r;
    fire = 1'b0;
    bad  = 1'b0;
    f1   = '0;
    f2   = '0;
    if (q_pop) begin
      if (q_item.start_req) begin
        s = clear_state(q_item.mode);
      end
      unique case (s.phase)
        PH_IDLE: begin
        end
        PH_SKIP: begin
          if ((s.mode[0] && q_item.info.is_csep) || q_item.info.is_ws) begin
            s.cnt = cnt_inc(s.cnt);
          end else if (q_item.info.is_nul) begin
            f1   = feed(no_drive(s), q_item.info);
            s    = f1.st;
            fire = f1.fire;
          end else begin
            s.held  = q_item.info;
            s.phase = PH_LOOK;
          end
        end
        PH_LOOK: begin
          if (q_item.info.is_colon) begin
            if (drv_ok) begin
              s.drv    = drv_ofs[4:0] + 5'd1;
              s.drv_wr = 1'b1;
              s.cnt    = cnt_inc(cnt_inc(s.cnt));
              s        = begin_name(s);
            end else begin
              fire    = 1'b1;
              bad     = 1'b1;
              s.phase = PH_IDLE;
            end
          end else begin
            // The held candidate is replayed as an ordinary character first; if it
            // already ends the parse, the character that came with it is dropped.
            f1 = feed(no_drive(s), s.held);
            f2 = feed(f1.st, q_item.info);
            if (f1.fire) begin
              s    = f1.st;
              fire = 1'b1;
            end else begin
              s    = f2.st;
              fire = f2.fire;
            end
          end
        end
        default: begin
          f1   = feed(s, q_item.info);
          s    = f1.st;
          fire = f1.fire;
        end
      endcase
    end
    st_nxt = s;
  end

  generate
    if (COUNT_WIDTH > 16) begin : g_wide_cnt
      assign cnt_sat = (|st_nxt.cnt[COUNT_WIDTH-1:16]) ? 16'hffff : st_nxt.cnt[15:0];
    end else begin : g_narrow_cnt
      assign cnt_sat = 16'(st_nxt.cnt);
    end
  endgenerate

  always_comb begin
    res_nxt.consumed = cnt_sat;
    if (bad) begin
      res_nxt.status     = ST_BAD_DRV;
      res_nxt.drive      = '0;
      res_nxt.drive_wr   = 1'b0;
      res_nxt.name_chars = '0;
      res_nxt.name_mask  = '0;
      res_nxt.ext_chars  = '0;
      res_nxt.ext_wr     = 1'b0;
    end else begin
      res_nxt.status     = st_nxt.wild ? ST_WILD : ST_OK;
      res_nxt.drive      = st_nxt.drv;
      res_nxt.drive_wr   = st_nxt.drv_wr;
      res_nxt.name_chars = st_nxt.name_buf;
      res_nxt.name_mask  = st_nxt.wmask;
      res_nxt.ext_chars  = st_nxt.ext_buf;
      res_nxt.ext_wr     = st_nxt.ext_wr;
    end
  end

  assign out_valid_nxt = (q_pop && fire) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= idle_state();
      out_valid_r   <= 1'b0;
    end else begin
      st_r          <= st_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

[design/fcb_filename_parser_unit.sv]
// 8.3 file name parser: one path character per cycle in while in_stall is low, one result per parse out.
// With the queue drained, a result is registered as the character ending the parse is
// popped from the queue. The two-entry queue and the output register set the stall behavior.
// Reset (rst_n low, synchronous) empties the queue, idles the parser and clears
// the valid-drive map to zero.
module fcb_filename_parser_unit import fcbp_pkg::*; #(
  parameter int unsigned NAME_LEN    = 8,
  parameter int unsigned EXT_LEN     = 3,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [DRV_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_ch,
  input  logic             in_start_req,
  input  logic [3:0]       in_mode,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [4:0]       out_drive,
  output logic             out_drive_written,
  output logic [63:0]      out_name_chars,
  output logic [7:0]       out_name_mask,
  output logic [23:0]      out_ext_chars,
  output logic             out_ext_written,
  output logic [15:0]      out_consumed
);

  logic [DRV_W-1:0] valid_drives_r;
  qitem_t           front_item;
  qitem_t           q_item;
  logic             q_full;
  logic             q_not_empty;
  logic             q_pop;
  res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_drives_r <= '0;
    end else if (cfg_wr_en) begin
      valid_drives_r <= cfg_wr_data;
    end
  end

  fcbp_front u_front (
    .in_ch        (in_ch),
    .in_start_req (in_start_req),
    .in_mode      (in_mode),
    .item         (front_item)
  );

  fcbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_not_empty)
  );

  fcbp_back #(
    .NAME_LEN    (NAME_LEN),
    .EXT_LEN     (EXT_LEN),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid_drives (valid_drives_r),
    .q_not_empty  (q_not_empty),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .res          (res)
  );

  assign in_stall          = q_full;
  assign out_status        = res.status;
  assign out_drive         = res.drive;
  assign out_drive_written = res.drive_wr;
  assign out_name_chars    = res.name_chars;
  assign out_name_mask     = res.name_mask;
  assign out_ext_chars     = res.ext_chars;
  assign out_ext_written   = res.ext_wr;
  assign out_consumed      = res.consumed;

endmodule
